// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a implies b in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a implies b in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/vrmr_pkg.sv =====
// Shared widths, codes and divider interface types for the ranker core.
// No dependencies.
package vrmr_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 48;
  localparam int SQ_W     = 64;
  localparam int PROD_W   = 48;
  localparam int VAR_W    = 47;
  localparam int RATIO_W  = 63;
  localparam int SCORE_W  = 16;
  localparam int MEAN_W   = 24;
  localparam int LVAR_W   = 32;
  localparam int DIV_NW   = 80;
  localparam int DIV_DW   = 64;
  localparam int DIV_CW   = 7;

  localparam logic [VAR_W-1:0]   VAR_CAP   = 47'h4000_0000_0000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hFFFF;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_COMPUTE = 1'b1;
  localparam logic [1:0] TGT_GLOBAL = 2'd0;
  localparam logic [1:0] TGT_LOCAL  = 2'd1;
  localparam logic [1:0] TGT_BOTH   = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/vrmr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module vrmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/vrmr_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on vrmr_pkg for widths and the request/response types.
module vrmr_div (
  input  logic                clk,
  input  logic                rst,
  input  vrmr_pkg::div_req_t  req,
  output vrmr_pkg::div_rsp_t  rsp
);

  logic [vrmr_pkg::DIV_DW:0]   rem;
  logic [vrmr_pkg::DIV_NW-1:0] quo;
  logic [vrmr_pkg::DIV_DW-1:0] dvs;
  logic [vrmr_pkg::DIV_CW-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [vrmr_pkg::DIV_DW:0]   shifted;
  logic [vrmr_pkg::DIV_DW:0]   rem_next;
  logic                        fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted  = {rem[vrmr_pkg::DIV_DW-1:0], quo[vrmr_pkg::DIV_NW-1]};
    fits     = shifted >= {1'b0, dvs};
    rem_next = fits ? shifted - {1'b0, dvs} : shifted;
  end

  // Iterate over all dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= vrmr_pkg::DIV_CW'(vrmr_pkg::DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[vrmr_pkg::DIV_NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == vrmr_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/core/variance_ratio_metric_ranker.sv =====
// Variance-ratio ranker: per-dimension sums live in one stats RAM, results in a second RAM.
// Load: each item reads, then modifies and writes back one stats entry.
// Compute: up to six divisions per dimension through the shared 80-step divider, then
// selection scans over the result RAM; one result per rank, last_result on the last.
// Reset is synchronous: control state and the stats valid bits clear,
// so every stats entry reads as zero; no clearing pass.
`include "assert_macros.svh"
module variance_ratio_metric_ranker #(
  parameter int NUM_DIMENSIONS = 16,
  parameter int MAX_SAMPLES    = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               operation,
  input  logic [1:0]         target,
  input  logic [3:0]         dimension,
  input  logic signed [23:0] sample_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         rank_position,
  output logic [3:0]         dimension_index,
  output logic [15:0]        score,
  output logic signed [23:0] local_mean,
  output logic [31:0]        local_variance,
  output logic               undefined_flag,
  output logic               last_result
);

  localparam int DIM_W = NUM_DIMENSIONS > 1 ? $clog2(NUM_DIMENSIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(NUM_DIMENSIONS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SAMPLES);

  typedef struct packed {
    logic signed [vrmr_pkg::SUM_W-1:0] gsum;
    logic [vrmr_pkg::SQ_W-1:0]         gsq;
    logic [CNT_W-1:0]                  gcnt;
    logic signed [vrmr_pkg::SUM_W-1:0] lsum;
    logic [vrmr_pkg::SQ_W-1:0]         lsq;
    logic [CNT_W-1:0]                  lcnt;
  } stats_t;

  typedef struct packed {
    logic [vrmr_pkg::RATIO_W-1:0]       ratio;
    logic signed [vrmr_pkg::MEAN_W-1:0] lmean;
    logic [vrmr_pkg::LVAR_W-1:0]        lvar;
    logic                               undef;
    logic [vrmr_pkg::SCORE_W-1:0]       score;
  } res_t;

  typedef enum logic [18:0] {
    ST_IDLE      = 19'h00001,
    ST_LOAD      = 19'h00002,
    ST_P1_READ   = 19'h00004,
    ST_P1_LATCH  = 19'h00008,
    ST_DIV_LSUM  = 19'h00010,
    ST_DIV_LSQ   = 19'h00020,
    ST_DIV_GSUM  = 19'h00040,
    ST_DIV_GSQ   = 19'h00080,
    ST_P1_SQ     = 19'h00100,
    ST_P1_VAR    = 19'h00200,
    ST_DIV_RATIO = 19'h00400,
    ST_P1_WRITE  = 19'h00800,
    ST_P2_READ   = 19'h01000,
    ST_P2_LATCH  = 19'h02000,
    ST_DIV_FRAC  = 19'h04000,
    ST_P2_WRITE  = 19'h08000,
    ST_SEL_SCAN  = 19'h10000,
    ST_SEL_DRAIN = 19'h20000,
    ST_EMIT      = 19'h40000
  } state_t;

  state_t state;

  // Stats RAM signals
  logic                    stat_we;
  logic [DIM_W-1:0]        stat_waddr;
  stats_t                  stat_wdata;
  logic [DIM_W-1:0]        stat_raddr;
  logic [$bits(stats_t)-1:0] stat_rdata;
  logic [NUM_DIMENSIONS-1:0] stat_valid;
  logic                    st_valid_q;
  stats_t                  st_rd;

  // Result RAM signals
  logic                    res_we;
  logic [DIM_W-1:0]        res_waddr;
  res_t                    res_wdata;
  logic [DIM_W-1:0]        res_raddr;
  logic [$bits(res_t)-1:0] res_rdata;
  res_t                    res_rd;

  // Load path
  logic [DIM_W-1:0]                   in_addr;
  logic                               in_load_ok;
  logic [vrmr_pkg::SAMPLE_W-1:0]      in_mag;
  logic                               accept;
  logic [DIM_W-1:0]                   ld_dim;
  logic [1:0]                         ld_tgt;
  logic signed [vrmr_pkg::SAMPLE_W-1:0] ld_x;
  logic [vrmr_pkg::PROD_W-1:0]        ld_sq;
  logic signed [vrmr_pkg::SUM_W-1:0]  ld_xext;
  logic [vrmr_pkg::SQ_W:0]            g_sq_sum;
  logic [vrmr_pkg::SQ_W:0]            l_sq_sum;
  stats_t                             ld_new;

  // Compute path
  logic [DIM_W-1:0]             d;
  stats_t                       st;
  logic [vrmr_pkg::MEAN_W-1:0]  lq;
  logic [vrmr_pkg::MEAN_W-1:0]  gq;
  logic [vrmr_pkg::SQ_W-1:0]    lmsq;
  logic [vrmr_pkg::SQ_W-1:0]    gmsq;
  logic [vrmr_pkg::PROD_W-1:0]  lm2;
  logic [vrmr_pkg::PROD_W-1:0]  gm2;
  logic [vrmr_pkg::VAR_W-1:0]   lvar_r;
  logic [vrmr_pkg::VAR_W-1:0]   gvar_r;
  logic [vrmr_pkg::VAR_W-1:0]   lvar_c;
  logic [vrmr_pkg::VAR_W-1:0]   gvar_c;
  logic                         undef_r;
  logic [vrmr_pkg::RATIO_W-1:0] ratio_r;
  logic [vrmr_pkg::SQ_W-1:0]    norm;
  logic [vrmr_pkg::SQ_W:0]      norm_sum;
  logic [vrmr_pkg::SUM_W-1:0]   l_abs;
  logic [vrmr_pkg::SUM_W-1:0]   g_abs;
  logic signed [vrmr_pkg::MEAN_W-1:0] lmean_c;
  res_t                         rw;

  // Selection
  logic [DIM_W-1:0]          rank;
  logic [DIM_W-1:0]          scan_idx;
  logic [DIM_W-1:0]          scan_idx_q;
  logic                      scan_vld_q;
  logic [NUM_DIMENSIONS-1:0] emitted;
  res_t                      best;
  logic [DIM_W-1:0]          best_idx;
  logic                      best_vld;
  logic                      out_free;

  // Divider
  vrmr_pkg::div_req_t div_req;
  vrmr_pkg::div_rsp_t div_rsp;
  logic               div_pending;
  logic               in_div;

  vrmr_ram #(.WIDTH($bits(stats_t)), .DEPTH(NUM_DIMENSIONS)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .raddr (stat_raddr),
    .rdata (stat_rdata)
  );

  vrmr_ram #(.WIDTH($bits(res_t)), .DEPTH(NUM_DIMENSIONS)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  vrmr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Decode the incoming item
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_addr    = DIM_W'(dimension);
  assign in_load_ok = (32'(dimension) < 32'(NUM_DIMENSIONS)) &&
                      (target == vrmr_pkg::TGT_GLOBAL || target == vrmr_pkg::TGT_LOCAL ||
                       target == vrmr_pkg::TGT_BOTH);
  assign in_mag     = sample_value[vrmr_pkg::SAMPLE_W-1] ?
                      vrmr_pkg::SAMPLE_W'(-sample_value) : vrmr_pkg::SAMPLE_W'(sample_value);

  // Entries never written since the last clear read as zero
  assign st_rd  = st_valid_q ? stats_t'(stat_rdata) : '0;
  assign res_rd = res_t'(res_rdata);
  assign stat_raddr = (state == ST_IDLE) ? in_addr : d;

  // Accumulate one sample into the entry read last cycle
  always_comb begin
    ld_xext  = {{(vrmr_pkg::SUM_W - vrmr_pkg::SAMPLE_W){ld_x[vrmr_pkg::SAMPLE_W-1]}}, ld_x};
    g_sq_sum = {1'b0, st_rd.gsq} + (vrmr_pkg::SQ_W + 1)'(ld_sq);
    l_sq_sum = {1'b0, st_rd.lsq} + (vrmr_pkg::SQ_W + 1)'(ld_sq);
    ld_new   = st_rd;
    if ((ld_tgt == vrmr_pkg::TGT_GLOBAL || ld_tgt == vrmr_pkg::TGT_BOTH) &&
        st_rd.gcnt < CNT_MAX) begin
      ld_new.gsum = st_rd.gsum + ld_xext;
      ld_new.gsq  = g_sq_sum[vrmr_pkg::SQ_W] ? '1 : g_sq_sum[vrmr_pkg::SQ_W-1:0];
      ld_new.gcnt = st_rd.gcnt + 1'b1;
    end
    if ((ld_tgt == vrmr_pkg::TGT_LOCAL || ld_tgt == vrmr_pkg::TGT_BOTH) &&
        st_rd.lcnt < CNT_MAX) begin
      ld_new.lsum = st_rd.lsum + ld_xext;
      ld_new.lsq  = l_sq_sum[vrmr_pkg::SQ_W] ? '1 : l_sq_sum[vrmr_pkg::SQ_W-1:0];
      ld_new.lcnt = st_rd.lcnt + 1'b1;
    end
  end

  assign stat_we    = (state == ST_LOAD);
  assign stat_waddr = ld_dim;
  assign stat_wdata = ld_new;

  // Variance terms: mean of squares minus square of mean, clamped
  always_comb begin
    logic [vrmr_pkg::SQ_W-1:0] ldiff;
    logic [vrmr_pkg::SQ_W-1:0] gdiff;
    ldiff = (lmsq > vrmr_pkg::SQ_W'(lm2)) ? lmsq - vrmr_pkg::SQ_W'(lm2) : '0;
    gdiff = (gmsq > vrmr_pkg::SQ_W'(gm2)) ? gmsq - vrmr_pkg::SQ_W'(gm2) : '0;
    lvar_c = (ldiff > vrmr_pkg::SQ_W'(vrmr_pkg::VAR_CAP)) ? vrmr_pkg::VAR_CAP :
             vrmr_pkg::VAR_W'(ldiff);
    gvar_c = (gdiff > vrmr_pkg::SQ_W'(vrmr_pkg::VAR_CAP)) ? vrmr_pkg::VAR_CAP :
             vrmr_pkg::VAR_W'(gdiff);
  end

  assign l_abs    = st.lsum[vrmr_pkg::SUM_W-1] ? vrmr_pkg::SUM_W'(-st.lsum) :
                    vrmr_pkg::SUM_W'(st.lsum);
  assign g_abs    = st.gsum[vrmr_pkg::SUM_W-1] ? vrmr_pkg::SUM_W'(-st.gsum) :
                    vrmr_pkg::SUM_W'(st.gsum);
  assign lmean_c  = st.lsum[vrmr_pkg::SUM_W-1] ? -$signed(lq) : $signed(lq);
  assign norm_sum = {1'b0, norm} + (vrmr_pkg::SQ_W + 1)'(ratio_r);

  // Divider operand select
  assign in_div = (state == ST_DIV_LSUM) || (state == ST_DIV_LSQ) ||
                  (state == ST_DIV_GSUM) || (state == ST_DIV_GSQ) ||
                  (state == ST_DIV_RATIO) || (state == ST_DIV_FRAC);

  always_comb begin
    div_req.start    = in_div && !div_pending;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      ST_DIV_LSUM: begin
        div_req.dividend = vrmr_pkg::DIV_NW'(l_abs);
        div_req.divisor  = vrmr_pkg::DIV_DW'(st.lcnt);
      end
      ST_DIV_LSQ: begin
        div_req.dividend = vrmr_pkg::DIV_NW'(st.lsq);
        div_req.divisor  = vrmr_pkg::DIV_DW'(st.lcnt);
      end
      ST_DIV_GSUM: begin
        div_req.dividend = vrmr_pkg::DIV_NW'(g_abs);
        div_req.divisor  = vrmr_pkg::DIV_DW'(st.gcnt);
      end
      ST_DIV_GSQ: begin
        div_req.dividend = vrmr_pkg::DIV_NW'(st.gsq);
        div_req.divisor  = vrmr_pkg::DIV_DW'(st.gcnt);
      end
      ST_DIV_RATIO: begin
        div_req.dividend = vrmr_pkg::DIV_NW'({lvar_r, 16'h0000});
        div_req.divisor  = vrmr_pkg::DIV_DW'(gvar_r);
      end
      ST_DIV_FRAC: begin
        div_req.dividend = vrmr_pkg::DIV_NW'({rw.ratio, 16'h0000});
        div_req.divisor  = norm;
      end
      default: begin
      end
    endcase
  end

  // Result RAM ports
  always_comb begin
    res_we    = 1'b0;
    res_waddr = d;
    res_wdata = rw;
    res_raddr = d;
    if (state == ST_P1_WRITE) begin
      res_we          = 1'b1;
      res_wdata.ratio = ratio_r;
      res_wdata.lmean = lmean_c;
      res_wdata.lvar  = vrmr_pkg::LVAR_W'(lvar_r[vrmr_pkg::VAR_W-1:16]);
      res_wdata.undef = undef_r;
      res_wdata.score = '0;
    end else if (state == ST_P2_WRITE) begin
      res_we = 1'b1;
    end
    if (state == ST_SEL_SCAN) begin
      res_raddr = scan_idx;
    end
  end

  assign out_free = !result_valid || !result_stall;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stat_valid   <= '0;
      st_valid_q   <= 1'b0;
      div_pending  <= 1'b0;
      scan_vld_q   <= 1'b0;
      best_vld     <= 1'b0;
      emitted      <= '0;
      result_valid <= 1'b0;
      d            <= '0;
      rank         <= '0;
      scan_idx     <= '0;
    end else begin
      st_valid_q <= stat_valid[stat_raddr];
      scan_vld_q <= (state == ST_SEL_SCAN);

      // Drop the output item once it is taken, unless the next one follows
      if (result_valid && !result_stall && state != ST_EMIT) begin
        result_valid <= 1'b0;
      end

      // Issue and retire divisions
      if (div_req.start) begin
        div_pending <= 1'b1;
      end else if (div_rsp.done) begin
        div_pending <= 1'b0;
      end

      // Track the lowest unemitted score, lower index wins ties
      if (scan_vld_q && !emitted[scan_idx_q] &&
          (!best_vld || res_rd.score < best.score)) begin
        best     <= res_rd;
        best_idx <= scan_idx_q;
        best_vld <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation == vrmr_pkg::OP_COMPUTE) begin
              norm  <= '0;
              d     <= '0;
              state <= ST_P1_READ;
            end else if (in_load_ok) begin
              ld_dim <= in_addr;
              ld_tgt <= target;
              ld_x   <= sample_value;
              ld_sq  <= in_mag * in_mag;
              state  <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          stat_valid[ld_dim] <= 1'b1;
          state              <= ST_IDLE;
        end
        ST_P1_READ: begin
          state <= ST_P1_LATCH;
        end
        ST_P1_LATCH: begin
          st   <= st_rd;
          lq   <= '0;
          gq   <= '0;
          lmsq <= '0;
          gmsq <= '0;
          if (st_rd.lcnt != '0) begin
            state <= ST_DIV_LSUM;
          end else if (st_rd.gcnt != '0) begin
            state <= ST_DIV_GSUM;
          end else begin
            state <= ST_P1_SQ;
          end
        end
        ST_DIV_LSUM: begin
          if (div_rsp.done && div_pending) begin
            lq    <= div_rsp.quotient[vrmr_pkg::MEAN_W-1:0];
            state <= ST_DIV_LSQ;
          end
        end
        ST_DIV_LSQ: begin
          if (div_rsp.done && div_pending) begin
            lmsq  <= div_rsp.quotient[vrmr_pkg::SQ_W-1:0];
            state <= (st.gcnt != '0) ? ST_DIV_GSUM : ST_P1_SQ;
          end
        end
        ST_DIV_GSUM: begin
          if (div_rsp.done && div_pending) begin
            gq    <= div_rsp.quotient[vrmr_pkg::MEAN_W-1:0];
            state <= ST_DIV_GSQ;
          end
        end
        ST_DIV_GSQ: begin
          if (div_rsp.done && div_pending) begin
            gmsq  <= div_rsp.quotient[vrmr_pkg::SQ_W-1:0];
            state <= ST_P1_SQ;
          end
        end
        ST_P1_SQ: begin
          lm2   <= lq * lq;
          gm2   <= gq * gq;
          state <= ST_P1_VAR;
        end
        ST_P1_VAR: begin
          lvar_r  <= lvar_c;
          gvar_r  <= gvar_c;
          ratio_r <= '0;
          undef_r <= (st.lcnt == '0) || (st.gcnt == '0) || (gvar_c == '0);
          if ((st.lcnt == '0) || (st.gcnt == '0) || (gvar_c == '0)) begin
            state <= ST_P1_WRITE;
          end else begin
            state <= ST_DIV_RATIO;
          end
        end
        ST_DIV_RATIO: begin
          if (div_rsp.done && div_pending) begin
            ratio_r <= vrmr_pkg::RATIO_W'(div_rsp.quotient);
            state   <= ST_P1_WRITE;
          end
        end
        ST_P1_WRITE: begin
          if (!undef_r) begin
            norm <= norm_sum[vrmr_pkg::SQ_W] ? '1 : norm_sum[vrmr_pkg::SQ_W-1:0];
          end
          if (d == LAST_DIM) begin
            // Sums are consumed: clear the store for the next run
            stat_valid <= '0;
            d          <= '0;
            state      <= ST_P2_READ;
          end else begin
            d     <= d + 1'b1;
            state <= ST_P1_READ;
          end
        end
        ST_P2_READ: begin
          state <= ST_P2_LATCH;
        end
        ST_P2_LATCH: begin
          if (res_rd.undef || norm == '0) begin
            rw    <= {res_rd.ratio, res_rd.lmean, res_rd.lvar, 1'b1,
                      vrmr_pkg::SCORE_W'(0)};
            state <= ST_P2_WRITE;
          end else if (vrmr_pkg::SQ_W'(res_rd.ratio) >= norm) begin
            rw    <= {res_rd.ratio, res_rd.lmean, res_rd.lvar, res_rd.undef,
                      vrmr_pkg::SCORE_MAX};
            state <= ST_P2_WRITE;
          end else begin
            rw    <= res_rd;
            state <= ST_DIV_FRAC;
          end
        end
        ST_DIV_FRAC: begin
          if (div_rsp.done && div_pending) begin
            rw.score <= div_rsp.quotient[vrmr_pkg::SCORE_W-1:0];
            state    <= ST_P2_WRITE;
          end
        end
        ST_P2_WRITE: begin
          if (d == LAST_DIM) begin
            d        <= '0;
            rank     <= '0;
            scan_idx <= '0;
            emitted  <= '0;
            best_vld <= 1'b0;
            state    <= ST_SEL_SCAN;
          end else begin
            d     <= d + 1'b1;
            state <= ST_P2_READ;
          end
        end
        ST_SEL_SCAN: begin
          scan_idx_q <= scan_idx;
          if (scan_idx == LAST_DIM) begin
            state <= ST_SEL_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_SEL_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            result_valid      <= 1'b1;
            rank_position     <= 4'(rank);
            dimension_index   <= 4'(best_idx);
            score             <= best.score;
            local_mean        <= best.lmean;
            local_variance    <= best.lvar;
            undefined_flag    <= best.undef;
            last_result       <= (rank == LAST_DIM);
            emitted[best_idx] <= 1'b1;
            best_vld          <= 1'b0;
            scan_idx          <= '0;
            if (rank == LAST_DIM) begin
              state <= ST_IDLE;
            end else begin
              rank  <= rank + 1'b1;
              state <= ST_SEL_SCAN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_last_rank, clk, rst, result_valid && last_result,
                  rank_position == 4'(NUM_DIMENSIONS - 1))
  `ASSERT_IMPLIES(a_undef_zero, clk, rst, result_valid && undefined_flag, score == '0)
  `ASSERT_IMPLIES(a_div_owned, clk, rst, div_rsp.done, div_pending)
  `ASSERT_IMPLIES(a_emit_best, clk, rst, state == ST_EMIT, best_vld)
  `ASSERT_NEXT(a_div_start, clk, rst, div_req.start, div_rsp.busy)

endmodule
